// File: design/assert_macros.svh
// Assertion macros used by the queue datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

`endif

// File: design/ccq_pkg.sv
// Types, codes and reset constants of the coalescing command queue.
`default_nettype none

package ccq_pkg;

    // Input item kinds.
    localparam logic [1:0] KIND_RECEIVE   = 2'd0;
    localparam logic [1:0] KIND_EXTRACT   = 2'd1;
    localparam logic [1:0] KIND_SUBSCRIBE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RETAINED_WINDOW = 2'd0;
    localparam logic [1:0] CFG_TTL_LIMIT       = 2'd1;
    localparam logic [1:0] CFG_EPHEMERAL_MASK  = 2'd2;
    localparam logic [1:0] CFG_ID_START        = 2'd3;

    // Reset values of the configuration.
    localparam logic [31:0] RETAINED_WINDOW_RST = 32'd10000;
    localparam logic [31:0] TTL_LIMIT_RST       = 32'd1800000;
    localparam logic [31:0] EPHEMERAL_MASK_RST  = 32'd127;
    localparam logic [31:0] ID_START_RST        = 32'd1;
    localparam int          ID_START_W          = 13;

    // Result status codes.
    typedef enum logic [3:0] {
        ST_QUEUED     = 4'd0,
        ST_UPDATED    = 4'd1,
        ST_EMPTY      = 4'd2,
        ST_RESIDUE    = 4'd3,
        ST_FULL       = 4'd4,
        ST_DELIVERED  = 4'd5,
        ST_EXPIRED    = 4'd6,
        ST_NOTHING    = 4'd7,
        ST_SUBSCRIBED = 4'd8
    } ccq_status_t;

    // One input beat.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
        logic [4:0]  opcode;
        logic [63:0] arg_bytes;
        logic [7:0]  payload_len;
    } ccq_item_t;

    // One result beat.
    typedef struct packed {
        logic [3:0]  status;
        logic [4:0]  out_opcode;
        logic [63:0] out_args;
        logic [3:0]  out_arg_count;
        logic [31:0] delivery_id;
        logic [3:0]  pending_count;
        logic        clear_retained;
        logic        last;
    } ccq_result_t;

    // One queue entry as kept in the entry memory.
    typedef struct packed {
        logic [4:0]  opcode;
        logic [63:0] args;
        logic [3:0]  arg_count;
        logic [31:0] stamp;
    } ccq_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        capture;
        logic        scan_start;
        logic        scan_next;
        logic        write_match;
        logic        append;
        logic        pop;
        logic        bump_id;
        logic        set_sub;
        logic        emit;
        ccq_status_t res_status;
        logic        res_last;
    } ccq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       empty_payload;
        logic       residue;
        logic       queue_empty;
        logic       queue_full;
        logic       match;
        logic       scan_last;
        logic       expired;
        logic       pop_empties;
        logic       out_free;
    } ccq_stat_t;

endpackage

`default_nettype wire

// File: design/ccq_ctrl.sv
// Controller state machine of the coalescing command queue.
`default_nettype none

module ccq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ccq_pkg::ccq_stat_t  dp_stat,
    output ccq_pkg::ccq_cmd_t   dp_cmd
);
    import ccq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_DECIDE  = 5'b00010,
        S_READ    = 5'b00100,
        S_CHECK   = 5'b01000,
        S_NOTHING = 5'b10000
    } ccq_state_t;

    ccq_state_t state_reg;
    ccq_state_t state_next;

    // An item is taken only while nothing is in progress.
    assign cmd_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (dp_stat.kind)
                    KIND_RECEIVE:
                    begin
                        if (dp_stat.empty_payload || dp_stat.residue
                            || dp_stat.queue_empty)
                        begin
                            if (dp_stat.out_free)
                            begin
                                dp_cmd.emit     = 1'b1;
                                dp_cmd.res_last = 1'b1;
                                if (dp_stat.empty_payload)
                                begin
                                    dp_cmd.res_status = ST_EMPTY;
                                end
                                else if (dp_stat.residue)
                                begin
                                    dp_cmd.res_status = ST_RESIDUE;
                                end
                                else
                                begin
                                    dp_cmd.res_status = ST_QUEUED;
                                    dp_cmd.append     = 1'b1;
                                end
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            dp_cmd.scan_start = 1'b1;
                            state_next        = S_READ;
                        end
                    end
                    KIND_EXTRACT:
                    begin
                        if (dp_stat.queue_empty)
                        begin
                            state_next = S_NOTHING;
                        end
                        else
                        begin
                            dp_cmd.scan_start = 1'b1;
                            state_next        = S_READ;
                        end
                    end
                    KIND_SUBSCRIBE:
                    begin
                        if (dp_stat.out_free)
                        begin
                            dp_cmd.set_sub    = 1'b1;
                            dp_cmd.emit       = 1'b1;
                            dp_cmd.res_last   = 1'b1;
                            dp_cmd.res_status = ST_SUBSCRIBED;
                            state_next        = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_NOTHING;
                    end
                endcase
            end
            S_READ:
            begin
                // The entry memory returns the addressed entry in the next cycle.
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (dp_stat.kind == KIND_EXTRACT)
                begin
                    if (dp_stat.out_free)
                    begin
                        dp_cmd.pop  = 1'b1;
                        dp_cmd.emit = 1'b1;
                        if (dp_stat.expired)
                        begin
                            dp_cmd.res_status = ST_EXPIRED;
                            state_next = dp_stat.pop_empties ? S_NOTHING : S_READ;
                        end
                        else
                        begin
                            dp_cmd.res_status = ST_DELIVERED;
                            dp_cmd.res_last   = 1'b1;
                            dp_cmd.bump_id    = 1'b1;
                            state_next        = S_IDLE;
                        end
                    end
                end
                else if (dp_stat.match || dp_stat.scan_last)
                begin
                    if (dp_stat.out_free)
                    begin
                        dp_cmd.emit     = 1'b1;
                        dp_cmd.res_last = 1'b1;
                        if (dp_stat.match)
                        begin
                            dp_cmd.write_match = 1'b1;
                            dp_cmd.res_status  = ST_UPDATED;
                        end
                        else if (dp_stat.queue_full)
                        begin
                            dp_cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            dp_cmd.append     = 1'b1;
                            dp_cmd.res_status = ST_QUEUED;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    dp_cmd.scan_next = 1'b1;
                    state_next       = S_READ;
                end
            end
            S_NOTHING:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.emit       = 1'b1;
                    dp_cmd.res_last   = 1'b1;
                    dp_cmd.res_status = ST_NOTHING;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ccq_dp.sv
// Datapath of the coalescing command queue: entry memory, pointers and result register.
`default_nettype none
`include "assert_macros.svh"

module ccq_dp #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ARG_BYTES   = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccq_pkg::ccq_item_t   cmd,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  ccq_pkg::ccq_cmd_t    dp_cmd,
    output ccq_pkg::ccq_stat_t   dp_stat,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ccq_pkg::ccq_result_t rsp
);
    import ccq_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Captured item and configuration.
    ccq_item_t   item_reg;
    logic [31:0] retained_window_reg;
    logic [31:0] ttl_limit_reg;
    logic [31:0] eph_mask_reg;
    logic [31:0] next_id_reg;
    logic [31:0] sub_time_reg;

    // Queue pointers and scan state.
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_left_reg;

    // Entry memory with registered read.
    ccq_entry_t entry_mem [QUEUE_DEPTH];
    ccq_entry_t rd_entry_reg;

    // Result register.
    ccq_result_t res_reg;
    logic        res_valid_reg;
    ccq_result_t res_next;
    logic        res_valid_next;

    logic [PTR_W-1:0] head_adv;
    logic [PTR_W-1:0] tail_adv;
    logic [PTR_W-1:0] ptr_adv;
    logic [CNT_W-1:0] count_after;
    logic [CNT_W+3:0] count_ext;
    logic [3:0]       keep_count;
    logic [63:0]      masked_args;
    ccq_entry_t       wr_entry;
    logic [PTR_W-1:0] wr_addr;
    logic             wr_en;
    logic [31:0]      since_sub;
    logic [31:0]      entry_age;
    logic             out_free;

    // Circular pointer advance.
    assign head_adv = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign ptr_adv  = (ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    // Stored byte count and argument bytes above it cleared.
    always_comb
    begin
        keep_count = (item_reg.payload_len < 8'(ARG_BYTES))
                   ? item_reg.payload_len[3:0] : 4'(ARG_BYTES);
        for (int b = 0; b < 8; b++)
        begin
            masked_args[8*b +: 8] = (4'(b) < keep_count) ? item_reg.arg_bytes[8*b +: 8]
                                                         : 8'h00;
        end
    end

    assign wr_entry.opcode    = item_reg.opcode;
    assign wr_entry.args      = masked_args;
    assign wr_entry.arg_count = keep_count;
    assign wr_entry.stamp     = item_reg.now;
    assign wr_en   = dp_cmd.write_match || dp_cmd.append;
    assign wr_addr = dp_cmd.append ? tail_reg : ptr_reg;

    // Age checks, all modulo 2^32.
    assign since_sub = item_reg.now - sub_time_reg;
    assign entry_age = item_reg.now - rd_entry_reg.stamp;

    assign out_free = !res_valid_reg || !rsp_stall;

    // Status toward the controller.
    assign dp_stat.kind          = item_reg.kind;
    assign dp_stat.empty_payload = (item_reg.payload_len == 8'd0);
    assign dp_stat.residue       = eph_mask_reg[item_reg.opcode]
                                   && (since_sub < retained_window_reg);
    assign dp_stat.queue_empty   = (count_reg == '0);
    assign dp_stat.queue_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign dp_stat.match         = (rd_entry_reg.opcode == item_reg.opcode);
    assign dp_stat.scan_last     = (scan_left_reg == CNT_W'(1));
    assign dp_stat.expired       = eph_mask_reg[rd_entry_reg.opcode]
                                   && (entry_age > ttl_limit_reg);
    assign dp_stat.pop_empties   = (count_reg == CNT_W'(1));
    assign dp_stat.out_free      = out_free;

    // Entry count once this cycle's command has taken effect.
    always_comb
    begin
        if (dp_cmd.append)
        begin
            count_after = count_reg + 1'b1;
        end
        else if (dp_cmd.pop)
        begin
            count_after = count_reg - 1'b1;
        end
        else
        begin
            count_after = count_reg;
        end
    end
    assign count_ext = {4'd0, count_after};

    // Result fields by status.
    always_comb
    begin
        res_next               = '0;
        res_next.status        = 4'(dp_cmd.res_status);
        res_next.last          = dp_cmd.res_last;
        res_next.pending_count = count_ext[3:0];
        case (dp_cmd.res_status)
            ST_QUEUED, ST_UPDATED, ST_EMPTY, ST_FULL:
            begin
                res_next.out_opcode = item_reg.opcode;
            end
            ST_RESIDUE:
            begin
                res_next.out_opcode     = item_reg.opcode;
                res_next.clear_retained = 1'b1;
            end
            ST_DELIVERED:
            begin
                res_next.out_opcode     = rd_entry_reg.opcode;
                res_next.out_args       = rd_entry_reg.args;
                res_next.out_arg_count  = rd_entry_reg.arg_count;
                res_next.delivery_id    = next_id_reg;
                res_next.clear_retained = 1'b1;
            end
            ST_EXPIRED:
            begin
                res_next.out_opcode     = rd_entry_reg.opcode;
                res_next.out_args       = rd_entry_reg.args;
                res_next.out_arg_count  = rd_entry_reg.arg_count;
                res_next.clear_retained = 1'b1;
            end
            default:
            begin
                res_next.out_opcode = 5'd0;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.emit)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && rsp_stall;
        end
    end

    // Control registers: configuration, pointers, counters, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retained_window_reg <= RETAINED_WINDOW_RST;
            ttl_limit_reg       <= TTL_LIMIT_RST;
            eph_mask_reg        <= EPHEMERAL_MASK_RST;
            next_id_reg         <= ID_START_RST;
            sub_time_reg        <= '0;
            head_reg            <= '0;
            tail_reg            <= '0;
            ptr_reg             <= '0;
            count_reg           <= '0;
            scan_left_reg       <= '0;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RETAINED_WINDOW: retained_window_reg <= cfg_data;
                    CFG_TTL_LIMIT:       ttl_limit_reg       <= cfg_data;
                    CFG_EPHEMERAL_MASK:  eph_mask_reg        <= cfg_data;
                    CFG_ID_START:
                        next_id_reg <= {{(32 - ID_START_W){1'b0}}, cfg_data[ID_START_W-1:0]};
                    default:             eph_mask_reg        <= eph_mask_reg;
                endcase
            end
            else if (dp_cmd.bump_id)
            begin
                next_id_reg <= next_id_reg + 32'd1;
            end
            if (dp_cmd.set_sub)
            begin
                sub_time_reg <= item_reg.now;
            end
            if (dp_cmd.scan_start)
            begin
                ptr_reg       <= head_reg;
                scan_left_reg <= count_reg;
            end
            else if (dp_cmd.scan_next || dp_cmd.pop)
            begin
                ptr_reg       <= ptr_adv;
                scan_left_reg <= scan_left_reg - 1'b1;
            end
            if (dp_cmd.append)
            begin
                tail_reg <= tail_adv;
            end
            if (dp_cmd.pop)
            begin
                head_reg <= head_adv;
            end
            count_reg     <= count_after;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers and the entry memory.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            item_reg <= cmd;
        end
        if (dp_cmd.emit)
        begin
            res_reg <= res_next;
        end
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= entry_mem[ptr_reg];
    end

    assign rsp_valid = res_valid_reg;
    assign rsp       = res_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_append_not_full, clk, rst_n, dp_cmd.append, count_reg != CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_pop_not_empty, clk, rst_n, dp_cmd.pop, count_reg != '0)
    `ASSERT_NEXT(a_emit_held, clk, rst_n, dp_cmd.emit && rsp_stall, rsp_valid)

endmodule

`default_nettype wire

// File: design/coalescing_command_queue_ttl.sv
// Top level of the coalescing command queue with residue filtering and expiry.
//
// Input channel cmd/cmd_valid/cmd_stall carries one beat per command: receive,
// extract or subscription. Results leave on rsp/rsp_valid/rsp_stall; every item
// gives one or more result beats and the final one has last set.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the queue is idle, which the block does not enforce. Writing id_start
// also reloads the delivery id counter. An item is taken in the idle state and is
// decided in the next cycle. Empty, residue and subscription items, and a receive
// into an empty queue, give their result from the decide state once the output
// register is free; an unknown kind passes through a nothing state first. A receive
// that searches the queue visits each entry with a registered read of the entry
// memory followed by a compare, and an extract pops entries the same way after the
// decide state, with a closing nothing result when the queue runs empty. One item
// is handled at a time; the next is taken as soon as the last result is loaded
// into the output register. When the receiver stalls, the result register holds
// its beat and the queue waits before producing another result. Reset empties the
// queue, loads the configuration defaults and sets the delivery id to its start
// value.
`default_nettype none

module coalescing_command_queue_ttl #(
    parameter int QUEUE_DEPTH = 8,
    parameter int ARG_BYTES   = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  ccq_pkg::ccq_item_t   cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ccq_pkg::ccq_result_t rsp,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    import ccq_pkg::*;

    ccq_cmd_t  dp_cmd;
    ccq_stat_t dp_stat;

    // Sequencing of each item.
    ccq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // Storage, checks and result formation.
    ccq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ARG_BYTES   (ARG_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: tb/tb_coalescing_command_queue_ttl.sv
// Self-checking testbench for the coalescing command queue with residue filtering and expiry.
`timescale 1ns / 1ps

module tb_coalescing_command_queue_ttl;
    import ccq_pkg::*;

    localparam int          QDEPTH       = 8;
    localparam int          KEEP_BYTES   = 8;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          RANDOM_ITEMS = 85;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [1:0]  KIND_UNKNOWN = 2'd3;

    // Mirror of the queue: it keeps its own copy of the entries and the
    // configuration and lists the result beats that each command must cause.
    class command_queue_mirror;
        logic [31:0] retained_window;
        logic [31:0] ttl_limit;
        logic [31:0] ephemeral_mask;
        logic [31:0] next_id;
        logic [31:0] subscribe_time;
        logic [4:0]  slot_opcode[QDEPTH];
        logic [63:0] slot_args[QDEPTH];
        logic [3:0]  slot_nbytes[QDEPTH];
        logic [31:0] slot_stamp[QDEPTH];
        int          fill;
        ccq_result_t due_results[$];
        int          errors;

        function new();
            retained_window = RETAINED_WINDOW_RST;
            ttl_limit       = TTL_LIMIT_RST;
            ephemeral_mask  = EPHEMERAL_MASK_RST;
            next_id         = ID_START_RST;
            subscribe_time  = '0;
            fill            = 0;
            errors          = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] value);
            case (index)
                CFG_RETAINED_WINDOW: retained_window = value;
                CFG_TTL_LIMIT:       ttl_limit = value;
                CFG_EPHEMERAL_MASK:  ephemeral_mask = value;
                CFG_ID_START:        next_id = {19'd0, value[ID_START_W-1:0]};
                default: ;
            endcase
        endfunction

        // Queue one expected beat; the pending count is the fill after the action.
        function void add(ccq_status_t st, logic [4:0] op, logic [63:0] args,
                          logic [3:0] nbytes, logic [31:0] id, logic clr);
            ccq_result_t r;
            r.status         = st;
            r.out_opcode     = op;
            r.out_args       = args;
            r.out_arg_count  = nbytes;
            r.delivery_id    = id;
            r.pending_count  = 4'(fill);
            r.clear_retained = clr;
            r.last           = 1'b0;
            due_results.push_back(r);
        endfunction

        function void accept_command(ccq_item_t it);
            logic [3:0]  nbytes;
            logic [63:0] kept;
            logic [4:0]  cop;
            logic [63:0] cargs;
            logic [3:0]  ccnt;
            logic [31:0] cstamp;
            int          hit;
            bit          delivered;
            ccq_result_t tail;

            case (it.kind)
                KIND_RECEIVE:
                begin
                    if (it.payload_len == 8'd0)
                    begin
                        add(ST_EMPTY, it.opcode, '0, '0, '0, 1'b0);
                    end
                    else if (ephemeral_mask[it.opcode] &&
                             (it.now - subscribe_time) < retained_window)
                    begin
                        add(ST_RESIDUE, it.opcode, '0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        // Keep at most eight bytes, zero the rest.
                        nbytes = (it.payload_len > KEEP_BYTES) ? 4'(KEEP_BYTES)
                                                               : it.payload_len[3:0];
                        kept = '0;
                        for (int b = 0; b < nbytes; b++)
                            kept[8*b +: 8] = it.arg_bytes[8*b +: 8];
                        hit = -1;
                        for (int i = 0; i < fill; i++)
                            if (hit < 0 && slot_opcode[i] == it.opcode)
                                hit = i;
                        if (hit >= 0)
                        begin
                            slot_args[hit]   = kept;
                            slot_nbytes[hit] = nbytes;
                            slot_stamp[hit]  = it.now;
                            add(ST_UPDATED, it.opcode, '0, '0, '0, 1'b0);
                        end
                        else if (fill >= QDEPTH)
                        begin
                            add(ST_FULL, it.opcode, '0, '0, '0, 1'b0);
                        end
                        else
                        begin
                            slot_opcode[fill] = it.opcode;
                            slot_args[fill]   = kept;
                            slot_nbytes[fill] = nbytes;
                            slot_stamp[fill]  = it.now;
                            fill++;
                            add(ST_QUEUED, it.opcode, '0, '0, '0, 1'b0);
                        end
                    end
                end
                KIND_EXTRACT:
                begin
                    // Pop from the head: expired ephemerals are reported until a
                    // live entry is delivered or the queue runs dry.
                    delivered = 1'b0;
                    while (!delivered && fill > 0)
                    begin
                        cop    = slot_opcode[0];
                        cargs  = slot_args[0];
                        ccnt   = slot_nbytes[0];
                        cstamp = slot_stamp[0];
                        for (int i = 1; i < fill; i++)
                        begin
                            slot_opcode[i-1] = slot_opcode[i];
                            slot_args[i-1]   = slot_args[i];
                            slot_nbytes[i-1] = slot_nbytes[i];
                            slot_stamp[i-1]  = slot_stamp[i];
                        end
                        fill--;
                        if (ephemeral_mask[cop] && (it.now - cstamp) > ttl_limit)
                        begin
                            add(ST_EXPIRED, cop, cargs, ccnt, '0, 1'b1);
                        end
                        else
                        begin
                            add(ST_DELIVERED, cop, cargs, ccnt, next_id, 1'b1);
                            next_id++;
                            delivered = 1'b1;
                        end
                    end
                    if (!delivered)
                        add(ST_NOTHING, '0, '0, '0, '0, 1'b0);
                end
                KIND_SUBSCRIBE:
                begin
                    subscribe_time = it.now;
                    add(ST_SUBSCRIBED, '0, '0, '0, '0, 1'b0);
                end
                default:
                begin
                    add(ST_NOTHING, '0, '0, '0, '0, 1'b0);
                end
            endcase

            // The final beat of this command carries last.
            tail = due_results.pop_back();
            tail.last = 1'b1;
            due_results.push_back(tail);
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch at %0t: %s", $realtime, what);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
                flag($sformatf("%s expected %0h got %0h", name, want, got));
        endfunction

        function void match_result(ccq_result_t got);
            ccq_result_t want;
            if (due_results.size() == 0)
            begin
                flag($sformatf("result beat with nothing expected, status %0d", got.status));
                return;
            end
            want = due_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_opcode", want.out_opcode, got.out_opcode);
            compare_field("out_args", want.out_args, got.out_args);
            compare_field("out_arg_count", want.out_arg_count, got.out_arg_count);
            compare_field("delivery_id", want.delivery_id, got.delivery_id);
            compare_field("pending_count", want.pending_count, got.pending_count);
            compare_field("clear_retained", want.clear_retained, got.clear_retained);
            compare_field("last", want.last, got.last);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    ccq_item_t   cmd       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    ccq_result_t rsp;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_RETAINED_WINDOW;
    logic [31:0] cfg_data  = '0;

    command_queue_mirror mirror = new();
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          cycle_count   = 0;
    logic [31:0] now_ms        = '0;
    int unsigned step_max      = 100;
    ccq_item_t   directed[$];

    coalescing_command_queue_ttl u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: check each accepted beat, then stall at random.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            mirror.match_result(rsp);
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic ccq_item_t mk(logic [1:0] kind, logic [31:0] now, logic [4:0] op,
                                     logic [63:0] args, logic [7:0] len);
        ccq_item_t it;
        it.kind        = kind;
        it.now         = now;
        it.opcode      = op;
        it.arg_bytes   = args;
        it.payload_len = len;
        return it;
    endfunction

    // Random command: time moves forward by small steps with rare jumps;
    // opcodes mostly come from a small set so entries coalesce and fill up.
    function automatic ccq_item_t random_command();
        int unsigned pick;
        logic [1:0]  kind;
        logic [4:0]  op;
        logic [7:0]  len;
        now_ms = now_ms + $urandom_range(step_max, 0);
        if ($urandom_range(49) == 0)
            now_ms = $urandom;
        pick = $urandom_range(99);
        kind = (pick < 55) ? KIND_RECEIVE : (pick < 85) ? KIND_EXTRACT :
               (pick < 97) ? KIND_SUBSCRIBE : KIND_UNKNOWN;
        op = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(11));
        pick = $urandom_range(99);
        len = (pick < 5) ? 8'd0 : (pick < 85) ? 8'($urandom_range(8, 1))
                                              : 8'($urandom_range(255, 9));
        return mk(kind, now_ms, op, {$urandom, $urandom}, len);
    endfunction

    // Present one command beat and hold it until it is taken.
    task automatic send_command(input ccq_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        mirror.accept_command(it);
    endtask

    // Stop sending and wait until every expected beat has come back.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (mirror.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers back to back while the queue is idle.
    task automatic program_regs(input logic [31:0] window, input logic [31:0] ttl,
                                input logic [31:0] mask, input logic [31:0] start);
        logic [1:0]  regs[4];
        logic [31:0] vals[4];
        regs = '{CFG_RETAINED_WINDOW, CFG_TTL_LIMIT, CFG_EPHEMERAL_MASK, CFG_ID_START};
        vals = '{window, ttl, mask, start};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            mirror.write_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        ccq_item_t it;
        int        sent;
        sent = 0;
        while (sent < count)
        begin
            it = random_command();
            send_command(it);
            if (!(it.kind == KIND_RECEIVE && it.payload_len == 8'd0))
                sent++;
            if ($urandom_range(39) == 0)
                drain();
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 6;
        stall_pct     = 73;

        // Directed commands under the reset configuration.
        directed.push_back(mk(KIND_EXTRACT, 32'd0, 5'd0, '0, 8'd0));
        directed.push_back(mk(KIND_UNKNOWN, 32'hFFFF_FFFF, 5'd31, '1, 8'd255));
        directed.push_back(mk(KIND_RECEIVE, 32'd100, 5'd3, '1, 8'd0));
        directed.push_back(mk(KIND_RECEIVE, 32'd5000, 5'd3, 64'h1122_3344_5566_7788, 8'd4));
        directed.push_back(mk(KIND_SUBSCRIBE, 32'd20000, 5'd0, '0, 8'd0));
        directed.push_back(mk(KIND_RECEIVE, 32'd20001, 5'd0, '1, 8'd8));
        directed.push_back(mk(KIND_RECEIVE, 32'd40000, 5'd31, '1, 8'd255));
        directed.push_back(mk(KIND_RECEIVE, 32'd40000, 5'd2, '1, 8'd1));
        directed.push_back(mk(KIND_RECEIVE, 32'd40001, 5'd31, 64'h0123_4567_89AB_CDEF, 8'd3));
        for (int i = 0; i < 6; i++)
            directed.push_back(mk(KIND_RECEIVE, 32'd40002, 5'(10 + i),
                                  {$urandom, $urandom}, 8'(i + 2)));
        directed.push_back(mk(KIND_RECEIVE, 32'd40003, 5'd20, '0, 8'd8));
        directed.push_back(mk(KIND_EXTRACT, 32'd40004, 5'd0, '0, 8'd0));
        // Head entry is one past its age limit and expires ahead of a delivery.
        directed.push_back(mk(KIND_EXTRACT, 32'd1840001, 5'd0, '0, 8'd0));
        directed.push_back(mk(KIND_RECEIVE, 32'hFFFF_FFFF, 5'd5, '0, 8'd9));
        // Subscription just before the time wraps; the residue window spans the wrap.
        directed.push_back(mk(KIND_SUBSCRIBE, 32'hFFFF_FFF0, 5'd0, '0, 8'd0));
        directed.push_back(mk(KIND_RECEIVE, 32'h0000_0005, 5'd6, '1, 8'd2));
        directed.push_back(mk(KIND_EXTRACT, 32'h0000_0010, 5'd0, '0, 8'd0));
        foreach (directed[i])
            send_command(directed[i]);
        drain();

        // Short windows and lifetimes, sender mostly busy, receiver mostly stalled.
        program_regs(32'd500, 32'd300, 32'h0000_0AAA, 32'd4096);
        now_ms   = 32'd50000;
        step_max = 200;
        random_phase(RANDOM_ITEMS);
        drain();

        // Zero window and zero lifetime with every opcode ephemeral.
        send_idle_pct = 73;
        stall_pct     = 6;
        program_regs(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
        step_max = 3;
        random_phase(RANDOM_ITEMS);
        drain();

        // Widest window and lifetime, time wrapping, no idling.
        send_idle_pct = 0;
        stall_pct     = 0;
        program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFF00_0F0F, 32'hFFFF_FFFF);
        now_ms   = 32'hFFFF_0000;
        step_max = 100000;
        random_phase(RANDOM_ITEMS);
        drain();

        // Middle settings with a random ephemeral mask.
        program_regs(32'd2000, 32'd1500, $urandom, 32'd100);
        step_max = 1000;
        random_phase(RANDOM_ITEMS);
        drain();

        repeat (20) @(posedge clk);
        if (mirror.errors == 0 && mirror.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/ccq_pkg.sv
design/ccq_ctrl.sv
design/ccq_dp.sv
design/coalescing_command_queue_ttl.sv
tb/tb_coalescing_command_queue_ttl.sv
